FILE: rtl/v3alu_pkg.sv
// Shared definitions for the three-component vector ALU.
// Holds operation codes, register indexes, default widths and the issue struct.
// No dependencies.
`timescale 1ns / 1ps

package v3alu_pkg;

	// Default fixed-point format (Q7.16 in a 24-bit word).
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 24;

	// Operation codes.
	localparam int OP_W = 3;
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_ADD   = 3'd0;
	localparam op_t OP_SUB   = 3'd1;
	localparam op_t OP_AVG   = 3'd2;
	localparam op_t OP_NORM  = 3'd3;
	localparam op_t OP_DOT   = 3'd4;
	localparam op_t OP_CROSS = 3'd5;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_OP   = 3'd0;
	localparam cfg_idx_t CFG_DA_X = 3'd1;
	localparam cfg_idx_t CFG_DA_Y = 3'd2;
	localparam cfg_idx_t CFG_DA_Z = 3'd3;
	localparam cfg_idx_t CFG_DB_X = 3'd4;
	localparam cfg_idx_t CFG_DB_Y = 3'd5;
	localparam cfg_idx_t CFG_DB_Z = 3'd6;

	// Front queue geometry.
	localparam int FQ_AW    = 2;
	localparam int FQ_DEPTH = 1 << FQ_AW;

	// Head of the front queue as seen by the back end.
	typedef struct packed {
		logic vld;
		op_t  op;
	} issue_t;

endpackage

FILE: rtl/v3alu_front.sv
// Front end of the vector ALU: configuration registers, default substitution
// and a short queue of classified items. Depends on v3alu_pkg.
`timescale 1ns / 1ps

module v3alu_front #(
	parameter int W = v3alu_pkg::WORD_BITS_DEF,
	parameter int F = v3alu_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      a_present,
	input  logic signed [W-1:0]       a_x,
	input  logic signed [W-1:0]       a_y,
	input  logic signed [W-1:0]       a_z,
	input  logic                      b_present,
	input  logic signed [W-1:0]       b_x,
	input  logic signed [W-1:0]       b_y,
	input  logic signed [W-1:0]       b_z,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  v3alu_pkg::cfg_idx_t       cfg_index,
	input  logic [W-1:0]              cfg_data,
	output v3alu_pkg::issue_t         iss,
	input  logic                      take,
	output logic signed [W-1:0]       iss_a [3],
	output logic signed [W-1:0]       iss_b [3]
);

	localparam logic [63:0] HALF64 = 64'd1 << (F - 1);
	localparam logic signed [W-1:0] HALF = HALF64[W-1:0];

	v3alu_pkg::op_t op_q;
	logic signed [W-1:0] da_q [3];
	logic signed [W-1:0] db_q [3];

	logic signed [W-1:0] in_a [3];
	logic signed [W-1:0] in_b [3];
	logic signed [W-1:0] sel_a [3];
	logic signed [W-1:0] sel_b [3];

	v3alu_pkg::op_t      fq_op_q [v3alu_pkg::FQ_DEPTH];
	logic signed [W-1:0] fq_a_q  [v3alu_pkg::FQ_DEPTH][3];
	logic signed [W-1:0] fq_b_q  [v3alu_pkg::FQ_DEPTH][3];
	logic [v3alu_pkg::FQ_AW-1:0] wr_ptr_q;
	logic [v3alu_pkg::FQ_AW-1:0] rd_ptr_q;
	logic [v3alu_pkg::FQ_AW:0]   cnt_q;
	logic push_xfer;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= v3alu_pkg::OP_ADD;
			for (int c = 0; c < 3; c++) begin
				da_q[c] <= HALF;
				db_q[c] <= HALF;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				v3alu_pkg::CFG_OP:   op_q    <= cfg_data[v3alu_pkg::OP_W-1:0];
				v3alu_pkg::CFG_DA_X: da_q[0] <= cfg_data;
				v3alu_pkg::CFG_DA_Y: da_q[1] <= cfg_data;
				v3alu_pkg::CFG_DA_Z: da_q[2] <= cfg_data;
				v3alu_pkg::CFG_DB_X: db_q[0] <= cfg_data;
				v3alu_pkg::CFG_DB_Y: db_q[1] <= cfg_data;
				v3alu_pkg::CFG_DB_Z: db_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Substitute the default vector for an operand that was not supplied.
	assign in_a[0] = a_x;
	assign in_a[1] = a_y;
	assign in_a[2] = a_z;
	assign in_b[0] = b_x;
	assign in_b[1] = b_y;
	assign in_b[2] = b_z;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sel_a[c] = a_present ? in_a[c] : da_q[c];
			sel_b[c] = b_present ? in_b[c] : db_q[c];
		end
	end

	// Queue storage: written at the tail on an input transfer.
	assign full      = cnt_q[v3alu_pkg::FQ_AW];
	assign push_xfer = push & ~full;

	always_ff @(posedge clk) begin
		if (push_xfer) begin
			fq_op_q[wr_ptr_q] <= op_q;
			for (int c = 0; c < 3; c++) begin
				fq_a_q[wr_ptr_q][c] <= sel_a[c];
				fq_b_q[wr_ptr_q][c] <= sel_b[c];
			end
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_xfer) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_xfer, take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// The head of the queue is offered to the back end.
	assign iss.vld = (cnt_q != '0);
	assign iss.op  = fq_op_q[rd_ptr_q];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			iss_a[c] = fq_a_q[rd_ptr_q][c];
			iss_b[c] = fq_b_q[rd_ptr_q][c];
		end
	end

endmodule

FILE: rtl/v3alu_back.sv
// Back end of the vector ALU: multiply, sum, pipelined square root and
// pipelined dividers, issued against a credit count. Depends on v3alu_pkg.
`timescale 1ns / 1ps

module v3alu_back #(
	parameter int W  = v3alu_pkg::WORD_BITS_DEF,
	parameter int F  = v3alu_pkg::FRAC_BITS_DEF,
	parameter int AW = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  v3alu_pkg::issue_t     iss,
	input  logic signed [W-1:0]   a [3],
	input  logic signed [W-1:0]   b [3],
	output logic                  take,
	input  logic                  out_xfer,
	output logic                  wr_en,
	output logic [4*W:0]          wr_data
);

	// Stages after the sum stage: square root, then division.
	localparam int NP = W + F + 1;
	localparam logic signed [2*W+1:0] MAXV = {{(W+3){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [2*W+1:0] MINV = {{(W+3){1'b1}}, {(W-1){1'b0}}};

	function automatic logic [W:0] sat_w(input logic signed [2*W+1:0] v);
		logic [W:0] r;
		if (v > MAXV) begin
			r = {1'b1, MAXV[W-1:0]};
		end else if (v < MINV) begin
			r = {1'b1, MINV[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	function automatic logic signed [2*W+1:0] px(input logic signed [2*W-1:0] p);
		return {{2{p[2*W-1]}}, p};
	endfunction

	// Credit count: items issued and not yet taken from the result queue.
	logic [AW:0] occ_q;

	assign take = iss.vld & ~occ_q[AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({take, out_xfer})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	// Stage 1: capture the issued item.
	logic                vld_s1;
	v3alu_pkg::op_t      op_s1;
	logic signed [W-1:0] a_s1 [3];
	logic signed [W-1:0] b_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= iss.op;
		for (int c = 0; c < 3; c++) begin
			a_s1[c] <= a[c];
			b_s1[c] <= b[c];
		end
	end

	// Stage 2: products, element-wise results, magnitudes for normalize.
	logic signed [W-1:0]   mx [6];
	logic signed [W-1:0]   my [6];
	logic signed [W:0]     sum_c [3];
	logic signed [W:0]     dif_c [3];
	logic [W:0]            ew_c [3];
	logic signed [W-1:0]   el_res [3];
	logic                  el_flag;

	logic                  vld_s2;
	v3alu_pkg::op_t        op_s2;
	logic signed [2*W-1:0] p_s2 [6];
	logic signed [W-1:0]   res_s2 [3];
	logic                  flag_s2;
	logic [W-1:0]          mag_s2 [3];
	logic [2:0]            sgn_s2;

	// Operand selection for the six shared multipliers.
	for (genvar i = 0; i < 3; i++) begin : g_mulsel
		always_comb begin
			if (op_s1 == v3alu_pkg::OP_CROSS) begin
				mx[i] = a_s1[(i + 1) % 3];
				my[i] = b_s1[(i + 2) % 3];
			end else if (op_s1 == v3alu_pkg::OP_NORM) begin
				mx[i] = a_s1[i];
				my[i] = a_s1[i];
			end else begin
				mx[i] = a_s1[i];
				my[i] = b_s1[i];
			end
			mx[i + 3] = a_s1[(i + 2) % 3];
			my[i + 3] = b_s1[(i + 1) % 3];
		end
	end

	always_comb begin
		el_flag = 1'b0;
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = {a_s1[c][W-1], a_s1[c]} + {b_s1[c][W-1], b_s1[c]};
			dif_c[c] = {a_s1[c][W-1], a_s1[c]} - {b_s1[c][W-1], b_s1[c]};
			case (op_s1)
				v3alu_pkg::OP_ADD: ew_c[c] = sat_w({{(W+1){sum_c[c][W]}}, sum_c[c]});
				v3alu_pkg::OP_SUB: ew_c[c] = sat_w({{(W+1){dif_c[c][W]}}, dif_c[c]});
				v3alu_pkg::OP_AVG: ew_c[c] = {1'b0, sum_c[c][W:1]};
				default:           ew_c[c] = '0;
			endcase
			el_res[c] = ew_c[c][W-1:0];
			el_flag   = el_flag | ew_c[c][W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2   <= op_s1;
		flag_s2 <= el_flag;
		for (int i = 0; i < 6; i++) begin
			p_s2[i] <= mx[i] * my[i];
		end
		for (int c = 0; c < 3; c++) begin
			res_s2[c] <= el_res[c];
			sgn_s2[c] <= a_s1[c][W-1];
			mag_s2[c] <= a_s1[c][W-1] ? -a_s1[c] : a_s1[c];
		end
	end

	// Stage 3: sums of products, scaling and saturation for dot and cross.
	logic signed [2*W+1:0] sum3;
	logic signed [2*W+1:0] cr_c [3];
	logic [W:0]            dsat;
	logic [W:0]            csat [3];
	logic signed [W-1:0]   s3_res [3];
	logic signed [W-1:0]   s3_scal;
	logic                  s3_flag;

	assign sum3 = px(p_s2[0]) + px(p_s2[1]) + px(p_s2[2]);
	assign dsat = sat_w(sum3 >>> F);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cr_c[c] = px(p_s2[c]) - px(p_s2[c + 3]);
			csat[c] = sat_w(cr_c[c] >>> F);
		end
		s3_res  = res_s2;
		s3_scal = '0;
		s3_flag = flag_s2;
		case (op_s2)
			v3alu_pkg::OP_DOT: begin
				for (int c = 0; c < 3; c++) begin
					s3_res[c] = dsat[W-1:0];
				end
				s3_scal = dsat[W-1:0];
				s3_flag = dsat[W];
			end
			v3alu_pkg::OP_CROSS: begin
				for (int c = 0; c < 3; c++) begin
					s3_res[c] = csat[c][W-1:0];
				end
				s3_flag = csat[0][W] | csat[1][W] | csat[2][W];
			end
			default: ;
		endcase
	end

	// Payload carried alongside the root and divider stages.
	logic                vld_p  [NP+1];
	logic signed [W-1:0] res_p  [NP+1][3];
	logic signed [W-1:0] scal_p [NP+1];
	logic                flag_p [NP+1];
	logic                norm_p [NP+1];
	logic                zero_p [NP+1];
	logic [2:0]          sgn_p  [NP+1];

	// Square root pipeline state, one result bit per stage.
	logic [2*W-1:0] sq_s_p    [W+1];
	logic [W+1:0]   sq_rem_p  [W+1];
	logic [W-1:0]   sq_root_p [W+1];
	logic [W-1:0]   mag_p     [W+1][3];

	// Divider pipeline state, one quotient bit per stage for each component.
	logic [W-1:0] dr_p  [1:F+1][3];
	logic [F:0]   q_p   [1:F+1][3];
	logic [W-1:0] len_p [1:F+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NP; k++) begin
				vld_p[k] <= 1'b0;
			end
		end else begin
			vld_p[0] <= vld_s2;
			for (int k = 0; k < NP; k++) begin
				vld_p[k + 1] <= vld_p[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_p[0]     <= s3_res;
		scal_p[0]    <= s3_scal;
		flag_p[0]    <= s3_flag;
		norm_p[0]    <= (op_s2 == v3alu_pkg::OP_NORM);
		zero_p[0]    <= (sum3[2*W-1:0] == '0);
		sgn_p[0]     <= sgn_s2;
		sq_s_p[0]    <= sum3[2*W-1:0];
		sq_rem_p[0]  <= '0;
		sq_root_p[0] <= '0;
		mag_p[0]     <= mag_s2;
		for (int k = 0; k < NP; k++) begin
			res_p[k + 1]  <= res_p[k];
			scal_p[k + 1] <= scal_p[k];
			flag_p[k + 1] <= flag_p[k];
			norm_p[k + 1] <= norm_p[k];
			zero_p[k + 1] <= zero_p[k];
			sgn_p[k + 1]  <= sgn_p[k];
		end
	end

	// Integer square root: bring down two bits of the sum, try the next root bit.
	for (genvar i = 0; i < W; i++) begin : g_sqrt
		logic [W+1:0] sh;
		logic [W+1:0] trial;
		logic [W+1:0] diff;
		logic         ge;

		assign sh    = {sq_rem_p[i][W-1:0], sq_s_p[i][2*W-1 -: 2]};
		assign trial = {sq_root_p[i], 2'b01};
		assign ge    = (sh >= trial);
		assign diff  = sh - trial;

		always_ff @(posedge clk) begin
			sq_rem_p[i + 1]  <= ge ? diff : sh;
			sq_root_p[i + 1] <= {sq_root_p[i][W-2:0], ge};
			sq_s_p[i + 1]    <= {sq_s_p[i][2*W-3:0], 2'b00};
			mag_p[i + 1]     <= mag_p[i];
		end
	end

	// Restoring division of magnitude * 2^F by the root; the magnitude never
	// exceeds the root, so the quotient fits F + 1 bits.
	for (genvar j = 0; j <= F; j++) begin : g_div
		logic [W-1:0] len_in;

		if (j == 0) begin : g_first
			assign len_in = sq_root_p[W];
		end else begin : g_next
			assign len_in = len_p[j];
		end

		always_ff @(posedge clk) begin
			len_p[j + 1] <= len_in;
		end

		for (genvar c = 0; c < 3; c++) begin : g_comp
			logic [W:0] t;
			logic [W:0] nxt;
			logic [F:0] qin;
			logic       ge;

			if (j == 0) begin : g_first
				assign t   = {1'b0, mag_p[W][c]};
				assign qin = '0;
			end else begin : g_next
				assign t   = {dr_p[j][c], 1'b0};
				assign qin = q_p[j][c];
			end

			assign ge  = (t >= {1'b0, len_in});
			assign nxt = ge ? (t - {1'b0, len_in}) : t;

			always_ff @(posedge clk) begin
				dr_p[j + 1][c] <= nxt[W-1:0];
				q_p[j + 1][c]  <= {qin[F-1:0], ge};
			end
		end
	end

	// Final selection: signed, saturated quotient for normalize (zero for a zero vector), else the carried result.
	logic signed [2*W+1:0] qe_c [3];
	logic signed [2*W+1:0] nv_c [3];
	logic [W:0]            ns_c [3];
	logic signed [W-1:0]   out_res [3];
	logic                  out_flag;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qe_c[c] = {{(2*W+1-F){1'b0}}, q_p[F+1][c]};
			nv_c[c] = sgn_p[NP][c] ? -qe_c[c] : qe_c[c];
			ns_c[c] = sat_w(nv_c[c]);
		end
		if (norm_p[NP]) begin
			if (zero_p[NP]) begin
				for (int c = 0; c < 3; c++) begin
					out_res[c] = '0;
				end
				out_flag = 1'b0;
			end else begin
				for (int c = 0; c < 3; c++) begin
					out_res[c] = ns_c[c][W-1:0];
				end
				out_flag = ns_c[0][W] | ns_c[1][W] | ns_c[2][W];
			end
		end else begin
			out_res  = res_p[NP];
			out_flag = flag_p[NP];
		end
	end

	assign wr_en   = vld_p[NP];
	assign wr_data = {out_flag, scal_p[NP], out_res[2], out_res[1], out_res[0]};

endmodule

FILE: rtl/v3alu_outq.sv
// Result queue of the vector ALU: a memory with a registered head entry.
// Depends on v3alu_pkg only for the default data width; no submodules.
`timescale 1ns / 1ps

module v3alu_outq #(
	parameter int DW = 4 * v3alu_pkg::WORD_BITS_DEF + 1,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [DW-1:0] wr_data,
	input  logic          pop,
	output logic          empty,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [1 << AW];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   mcnt_q;
	logic          head_vld_q;
	logic [DW-1:0] head_q;
	logic          pop_xfer;
	logic          load;

	assign empty    = ~head_vld_q;
	assign rd_data  = head_q;
	assign pop_xfer = pop & head_vld_q;
	assign load     = (mcnt_q != '0) & (~head_vld_q | pop_xfer);

	// Memory write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Registered read into the head entry.
	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= mem[rd_ptr_q];
		end
	end

	// Pointers, fill count and head valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			mcnt_q     <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, load})
				2'b10:   mcnt_q <= mcnt_q + 1'b1;
				2'b01:   mcnt_q <= mcnt_q - 1'b1;
				default: mcnt_q <= mcnt_q;
			endcase
			if (load) begin
				head_vld_q <= 1'b1;
			end else if (pop_xfer) begin
				head_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/vector3_alu.sv
// Top level of the three-component vector ALU in signed fixed point.
// Instantiates v3alu_front, v3alu_back and v3alu_outq; uses v3alu_pkg.
//
// Usage:
// Input items enter through a queue interface: an item transfers at a rising
// edge with push high and full low. Results leave through a queue interface:
// the oldest result sits on res_x/res_y/res_z/scalar_value/saturated while
// empty is low and transfers at a rising edge with pop high.
// Configuration (operation, default vectors A and B) is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. Write it
// only while no item is in flight.
// Pipeline: an item passes the front queue, the capture, product and sum
// stages, the square root, one result bit per stage, and the dividers, one
// quotient bit per stage, before it is written to the result queue.
// Throughput: one item per cycle, sustained while full stays low.
// Reset clears the configuration to operation add with both defaults at 0.5,
// and empties all queues and pipeline stages.
// When the receiver stalls, results collect in the result queue; once it and
// the pipeline hold a full queue of items, issue stops and the four-entry
// front queue fills, after which full goes high.
`timescale 1ns / 1ps

module vector3_alu #(
	parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        a_present,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic                        b_present,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [WORD_BITS-1:0] res_x,
	output logic signed [WORD_BITS-1:0] res_y,
	output logic signed [WORD_BITS-1:0] res_z,
	output logic signed [WORD_BITS-1:0] scalar_value,
	output logic                        saturated,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  v3alu_pkg::cfg_idx_t         cfg_index,
	input  logic [WORD_BITS-1:0]        cfg_data
);

	// Issue-to-queue-write latency and result queue size.
	localparam int LAT   = WORD_BITS + FRAC_BITS + 4;
	localparam int OQ_AW = $clog2(LAT + 4);
	localparam int DW    = 4 * WORD_BITS + 1;

	v3alu_pkg::issue_t           iss;
	logic                        take;
	logic signed [WORD_BITS-1:0] iss_a [3];
	logic signed [WORD_BITS-1:0] iss_b [3];
	logic                        wr_en;
	logic [DW-1:0]               wr_data;
	logic [DW-1:0]               rd_data;
	logic                        out_xfer;

	assign out_xfer = pop & ~empty;

	v3alu_front #(
		.W (WORD_BITS),
		.F (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.a_present (a_present),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_present (b_present),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.iss       (iss),
		.take      (take),
		.iss_a     (iss_a),
		.iss_b     (iss_b)
	);

	v3alu_back #(
		.W  (WORD_BITS),
		.F  (FRAC_BITS),
		.AW (OQ_AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss      (iss),
		.a        (iss_a),
		.b        (iss_b),
		.take     (take),
		.out_xfer (out_xfer),
		.wr_en    (wr_en),
		.wr_data  (wr_data)
	);

	v3alu_outq #(
		.DW (DW),
		.AW (OQ_AW)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.pop     (pop),
		.empty   (empty),
		.rd_data (rd_data)
	);

	// Unpack the head entry onto the result ports.
	assign res_x        = rd_data[WORD_BITS-1:0];
	assign res_y        = rd_data[2*WORD_BITS-1:WORD_BITS];
	assign res_z        = rd_data[3*WORD_BITS-1:2*WORD_BITS];
	assign scalar_value = rd_data[4*WORD_BITS-1:3*WORD_BITS];
	assign saturated    = rd_data[4*WORD_BITS];

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the three-component vector ALU (vector3_alu).
// Predicts each result in place and compares it against the result queue.
// Depends on v3alu_pkg and the RTL of vector3_alu.
`timescale 1ns / 1ps

module testbench;

	localparam int FB = v3alu_pkg::FRAC_BITS_DEF;
	localparam int WB = v3alu_pkg::WORD_BITS_DEF;
	localparam longint WMAX = (64'sd1 <<< (WB - 1)) - 1;
	localparam longint WMIN = -WMAX - 1;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam int LATENCY = WB + FB + 6;
	localparam int WATCHDOG = 5000;

	typedef struct {
		logic [WB-1:0] x, y, z, s;
		logic          sat;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, cfg_ready, saturated;
	logic a_present = 1'b0, b_present = 1'b0;
	logic signed [WB-1:0] a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
	logic signed [WB-1:0] res_x, res_y, res_z, scalar_value;
	logic cfg_valid = 1'b0;
	v3alu_pkg::cfg_idx_t cfg_index = v3alu_pkg::CFG_OP;
	logic [WB-1:0] cfg_data = '0;

	// Testbench copy of the configuration.
	v3alu_pkg::op_t cur_op;
	longint dflt_a [3];
	longint dflt_b [3];

	alu_result_t expected_results [$];
	int errors = 0;
	int idle_cycles = 0;

	vector3_alu u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Clip to the word range, raising the flag on overflow.
	function automatic longint clip(longint v, ref logic f);
		if (v > WMAX) begin
			f = 1'b1;
			return WMAX;
		end
		if (v < WMIN) begin
			f = 1'b1;
			return WMIN;
		end
		return v;
	endfunction

	// Integer square root, rounded down.
	function automatic longint int_sqrt(longint s);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'd3037000499;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= s) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// Expected ALU result for one input pair under the current configuration.
	function automatic alu_result_t compute_alu(logic ap, longint ain [3], logic bp,
		longint bin [3]);
		longint a [3], b [3], r [3], sc, s, len, m, q;
		logic f;
		alu_result_t res;
		f = 1'b0;
		sc = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = ap ? ain[i] : dflt_a[i];
			b[i] = bp ? bin[i] : dflt_b[i];
			r[i] = 0;
		end
		case (cur_op)
			v3alu_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i], f);
			v3alu_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i], f);
			v3alu_pkg::OP_AVG:
				for (int i = 0; i < 3; i++) r[i] = clip((a[i] + b[i]) >>> 1, f);
			v3alu_pkg::OP_NORM: begin
				s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
				if (s != 0) begin
					len = int_sqrt(s);
					for (int i = 0; i < 3; i++) begin
						m = a[i] < 0 ? -a[i] : a[i];
						q = (m <<< FB) / len;
						r[i] = clip(a[i] < 0 ? -q : q, f);
					end
				end
			end
			v3alu_pkg::OP_DOT: begin
				// Arithmetic shift floors, as the rounding calls for.
				sc = clip((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FB, f);
				r[0] = sc;
				r[1] = sc;
				r[2] = sc;
			end
			v3alu_pkg::OP_CROSS: begin
				r[0] = clip((a[1] * b[2] - a[2] * b[1]) >>> FB, f);
				r[1] = clip((a[2] * b[0] - a[0] * b[2]) >>> FB, f);
				r[2] = clip((a[0] * b[1] - a[1] * b[0]) >>> FB, f);
			end
			default: ;
		endcase
		res.x = r[0][WB-1:0];
		res.y = r[1][WB-1:0];
		res.z = r[2][WB-1:0];
		res.s = sc[WB-1:0];
		res.sat = f;
		return res;
	endfunction

	// Write one register while the block is idle.
	task automatic write_reg(v3alu_pkg::cfg_idx_t idx, logic [WB-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == v3alu_pkg::CFG_OP) cur_op = v3alu_pkg::op_t'(data);
		else if (idx <= v3alu_pkg::CFG_DA_Z)
			dflt_a[idx - v3alu_pkg::CFG_DA_X] = longint'(signed'(data));
		else dflt_b[idx - v3alu_pkg::CFG_DB_X] = longint'(signed'(data));
	endtask

	// Send one vector pair and record its expected result. Push stays high after
	// the transfer so that the next item can follow directly; drain lowers it.
	task automatic send_pair(logic ap, longint ax, longint ay, longint az,
		logic bp, longint bx, longint by, longint bz);
		longint av [3], bv [3];
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		av = '{ax, ay, az};
		bv = '{bx, by, bz};
		push <= 1'b1;
		a_present <= ap;
		b_present <= bp;
		a_x <= ax[WB-1:0];
		a_y <= ay[WB-1:0];
		a_z <= az[WB-1:0];
		b_x <= bx[WB-1:0];
		b_y <= by[WB-1:0];
		b_z <= bz[WB-1:0];
		do @(posedge clk); while (full);
		expected_results.push_back(compute_alu(ap, av, bp, bv));
		@(negedge clk);
	endtask

	// Wait until every expected result has arrived, then let the pipeline drain.
	task automatic drain;
		push <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic longint rand_word();
		case ($urandom_range(0, 5))
			0: return WMAX;
			1: return WMIN;
			2: return longint'($urandom_range(0, 2 * ONE)) - ONE;
			3: return longint'($urandom_range(0, 512)) - 256;
			default: return longint'(signed'(WB'($urandom)));
		endcase
	endfunction

	task automatic send_random;
		send_pair($urandom_range(0, 3) != 0, rand_word(), rand_word(), rand_word(),
			$urandom_range(0, 3) != 0, rand_word(), rand_word(), rand_word());
	endtask

	// Extremes, zero vectors and defaults under every operation.
	task automatic test_directed;
		for (int op = v3alu_pkg::OP_ADD; op <= v3alu_pkg::OP_CROSS; op++) begin
			write_reg(v3alu_pkg::CFG_OP, WB'(op));
			send_pair(1, WMAX, WMAX, WMAX, 1, WMAX, WMAX, WMAX);
			send_pair(1, WMIN, WMIN, WMIN, 1, WMAX, WMIN, WMAX);
			send_pair(1, 0, 0, 0, 1, -1, 1, 0);
			send_pair(0, 0, 0, 0, 0, 0, 0, 0);
			drain();
		end
	endtask

	// Default registers at their extremes, zero and minus one, under every op code, unused ones too.
	task automatic test_config_extremes;
		longint vals [4];
		vals = '{WMAX, WMIN, 0, -ONE};
		for (int k = 0; k < 4; k++) begin
			for (int r = v3alu_pkg::CFG_DA_X; r <= v3alu_pkg::CFG_DB_Z; r++)
				write_reg(v3alu_pkg::cfg_idx_t'(r), vals[(k + r) % 4][WB-1:0]);
			for (int op = 0; op < 8; op++) begin
				write_reg(v3alu_pkg::CFG_OP, WB'(op));
				send_pair(0, 0, 0, 0, 0, 0, 0, 0);
				send_pair(1, rand_word(), 0, 0, 0, 0, 0, 0);
				drain();
			end
		end
	endtask

	// Random pairs in phases, each with a fresh configuration.
	task automatic test_random;
		for (int ph = 0; ph < 18; ph++) begin
			for (int r = v3alu_pkg::CFG_DA_X; r <= v3alu_pkg::CFG_DB_Z; r++)
				write_reg(v3alu_pkg::cfg_idx_t'(r), WB'(rand_word()));
			write_reg(v3alu_pkg::CFG_OP, WB'(ph < 12 ? ph % 6 : $urandom_range(0, 7)));
			repeat (48) send_random();
			drain();
		end
	endtask

	// Receiver: random stalls, compare each result transfer.
	initial begin
		int st;
		alu_result_t e;
		forever begin
			@(negedge clk);
			st = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (st != 0) begin
				pop <= 1'b0;
				repeat (st) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: %h %h %h %h %b", $time,
					res_x, res_y, res_z, scalar_value, saturated);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (e.x !== res_x || e.y !== res_y || e.z !== res_z || e.s !== scalar_value
					|| e.sat !== saturated) begin
					$display("%0t: expected %h %h %h %h %b, got %h %h %h %h %b", $time,
						e.x, e.y, e.z, e.s, e.sat, res_x, res_y, res_z, scalar_value,
						saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		cur_op = v3alu_pkg::OP_ADD;
		for (int i = 0; i < 3; i++) begin
			dflt_a[i] = ONE / 2;
			dflt_b[i] = ONE / 2;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Reset defaults first, then directed, then configuration sweep and random.
		repeat (5) send_random();
		drain();
		test_directed();
		test_config_extremes();
		test_random();
		drain();
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
